[rtl/core/trlt_pkg.sv]
// Package for the tile lease table: widths, codes, state type and control structs.
`default_nettype none
package trlt_pkg;

    // Field widths of the channels
    localparam int ACTION_W   = 2;
    localparam int COORD_W    = 16;
    localparam int SLOT_W     = 16;
    localparam int TICK_W     = 32;
    localparam int HOLD_W     = 16;
    localparam int EXPIRY_W   = TICK_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Defaults for the top-level parameters
    localparam int MAX_SIDE_DEF  = 64;
    localparam int SLOT_BITS_DEF = 16;

    // Grid size after reset
    localparam logic [CFG_DATA_W-1:0] GRID_SIDE_RESET = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_QUERY   = 2'd0,
        ACT_RESERVE = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_EXPIRE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_EVAL,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic calc_idx;
        logic rd_single;
        logic eval;
        logic sweep_rd;
        logic sweep_end;
        logic clear_wr;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

[rtl/core/trlt_req_if.sv]
// Request channel of the tile lease table.
`default_nettype none
interface trlt_req_if;
    logic                          valid;
    logic                          ready;
    logic [trlt_pkg::ACTION_W-1:0] action;
    logic signed [trlt_pkg::COORD_W-1:0] tile_x;
    logic signed [trlt_pkg::COORD_W-1:0] tile_y;
    logic [trlt_pkg::SLOT_W-1:0]   slot;
    logic [trlt_pkg::TICK_W-1:0]   now_tick;
    logic [trlt_pkg::HOLD_W-1:0]   hold_ticks;

    modport source (output valid, action, tile_x, tile_y, slot, now_tick, hold_ticks,
                    input ready);
    modport sink   (input valid, action, tile_x, tile_y, slot, now_tick, hold_ticks,
                    output ready);
endinterface
`default_nettype wire

[rtl/core/trlt_rsp_if.sv]
// Result channel of the tile lease table.
`default_nettype none
interface trlt_rsp_if;
    logic valid;
    logic ready;
    logic granted;

    modport source (output valid, granted, input ready);
    modport sink   (input valid, granted, output ready);
endinterface
`default_nettype wire

[rtl/core/trlt_cfg_if.sv]
// Configuration write channel of the tile lease table.
`default_nettype none
interface trlt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [trlt_pkg::CFG_IDX_W-1:0]  index;
    logic [trlt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/trlt_ctrl.sv]
// Controller state machine of the tile lease table.
`default_nettype none
module trlt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire trlt_pkg::action_t req_action,
    input  wire trlt_pkg::status_t status,
    output logic                   req_ready,
    output trlt_pkg::cmd_t         cmd,
    output trlt_pkg::state_t       state
);
    import trlt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_action == ACT_QUERY || req_action == ACT_RESERVE)
                    begin
                        state_next = ST_INDEX;
                    end
                    else
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_INDEX: state_next = ST_READ;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_DONE;
            ST_SWEEP:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_wr = 1'b1;
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_INDEX: cmd.calc_idx  = 1'b1;
            ST_READ:  cmd.rd_single = 1'b1;
            ST_EVAL:  cmd.eval      = 1'b1;
            ST_SWEEP: cmd.sweep_rd  = 1'b1;
            ST_DRAIN: cmd.sweep_end = 1'b1;
            ST_DONE:  cmd.out_load  = status.out_free;
            default:  cmd = '0;
        endcase
    end

    assign state = state_reg;

endmodule
`default_nettype wire

[rtl/core/trlt_datapath.sv]
// Datapath of the tile lease table: lease store, index unit, sweep counter, result register.
`default_nettype none
module trlt_datapath #(
    parameter int MAX_SIDE  = trlt_pkg::MAX_SIDE_DEF,
    parameter int SLOT_BITS = trlt_pkg::SLOT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire trlt_pkg::cmd_t                      cmd,
    output trlt_pkg::status_t                        status,
    input  wire logic [trlt_pkg::ACTION_W-1:0]       in_action,
    input  wire logic signed [trlt_pkg::COORD_W-1:0] in_tile_x,
    input  wire logic signed [trlt_pkg::COORD_W-1:0] in_tile_y,
    input  wire logic [trlt_pkg::SLOT_W-1:0]         in_slot,
    input  wire logic [trlt_pkg::TICK_W-1:0]         in_now_tick,
    input  wire logic [trlt_pkg::HOLD_W-1:0]         in_hold_ticks,
    input  wire logic                                cfg_write,
    input  wire logic [trlt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [trlt_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     out_valid,
    output logic                                     out_granted,
    input  wire logic                                out_ready
);
    import trlt_pkg::*;

    localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int CMP_W      = (SIDE_W > CFG_DATA_W) ? SIDE_W : CFG_DATA_W;
    localparam int PROD_W     = 2 * SIDE_W;
    localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(CELL_COUNT - 1);
    localparam logic [SLOT_BITS-1:0] SLOT_NONE = '1;

    // Lease store
    logic [SLOT_BITS-1:0] owner_mem  [CELL_COUNT];
    logic [EXPIRY_W-1:0]  expiry_mem [CELL_COUNT];

    // Captured request
    action_t                    action_reg;
    logic signed [COORD_W-1:0]  x_reg;
    logic signed [COORD_W-1:0]  y_reg;
    logic [SLOT_BITS-1:0]       slot_reg;
    logic [TICK_W-1:0]          now_reg;
    logic [HOLD_W-1:0]          hold_reg;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             inb_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_addr_reg;
    logic             result_reg;
    logic             out_valid_reg;
    logic             out_granted_reg;

    logic [SLOT_BITS-1:0] owner_rd_reg;
    logic [EXPIRY_W-1:0]  expiry_rd_reg;

    logic [CMP_W-1:0]  w_clip;
    logic [CMP_W-1:0]  h_clip;
    logic [SIDE_W-1:0] eff_w;
    logic [SIDE_W-1:0] eff_h;
    logic              in_bounds;
    logic [PROD_W-1:0] cell_idx;

    logic                 lapsed;
    logic                 cell_free;
    logic                 take;
    logic                 sweep_hit;
    logic [EXPIRY_W-1:0]  new_expiry;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SLOT_BITS-1:0] wr_owner;
    logic [EXPIRY_W-1:0]  wr_expiry;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(in_action);
            x_reg      <= in_tile_x;
            y_reg      <= in_tile_y;
            slot_reg   <= SLOT_BITS'(in_slot);
            now_reg    <= in_now_tick;
            hold_reg   <= in_hold_ticks;
        end
    end

    // Grid size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= GRID_SIDE_RESET;
            height_reg <= GRID_SIDE_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_GRID_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == REG_GRID_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // Bounds check and cell index; an oversized side counts as the maximum
    always_comb
    begin
        w_clip = (CMP_W'(width_reg) > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE)
                                                       : CMP_W'(width_reg);
        h_clip = (CMP_W'(height_reg) > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE)
                                                        : CMP_W'(height_reg);
        eff_w  = SIDE_W'(w_clip);
        eff_h  = SIDE_W'(h_clip);
        in_bounds = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
                 && ($unsigned(x_reg) < COORD_W'(eff_w))
                 && ($unsigned(y_reg) < COORD_W'(eff_h));
        cell_idx  = PROD_W'(y_reg[SIDE_W-1:0]) * PROD_W'(eff_w)
                  + PROD_W'(x_reg[SIDE_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_idx)
        begin
            idx_reg <= IDX_W'(cell_idx);
            inb_reg <= in_bounds;
        end
    end

    // Sweep counter, shared by the clearing pass and release/expire sweeps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.clear_wr || cmd.sweep_rd)
        begin
            cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
        end
    end

    // A swept cell is written back in the cycle after its read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.sweep_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_rd)
        begin
            pend_addr_reg <= cnt_reg;
        end
    end

    // Cell evaluation on the registered read data
    always_comb
    begin
        lapsed     = expiry_rd_reg <= EXPIRY_W'(now_reg);
        cell_free  = (owner_rd_reg == SLOT_NONE) || lapsed;
        take       = inb_reg && (cell_free || (slot_reg < owner_rd_reg));
        new_expiry = EXPIRY_W'(now_reg) + EXPIRY_W'(hold_reg) + EXPIRY_W'(1);
        if (action_reg == ACT_RELEASE)
        begin
            sweep_hit = owner_rd_reg == slot_reg;
        end
        else
        begin
            sweep_hit = (owner_rd_reg != SLOT_NONE) && lapsed;
        end
    end

    // Store port selection
    always_comb
    begin
        rd_en     = cmd.rd_single || cmd.sweep_rd;
        rd_addr   = cmd.sweep_rd ? cnt_reg : idx_reg;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_owner  = SLOT_NONE;
        wr_expiry = '0;
        priority if (cmd.clear_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
        end
        else if (pend_reg)
        begin
            wr_en   = sweep_hit;
            wr_addr = pend_addr_reg;
        end
        else if (cmd.eval && action_reg == ACT_RESERVE)
        begin
            wr_en     = take;
            wr_owner  = slot_reg;
            wr_expiry = new_expiry;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    // Lease store, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_mem[wr_addr]  <= wr_owner;
            expiry_mem[wr_addr] <= wr_expiry;
        end
        if (rd_en)
        begin
            owner_rd_reg  <= owner_mem[rd_addr];
            expiry_rd_reg <= expiry_mem[rd_addr];
        end
    end

    // Answer of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            result_reg <= (action_reg == ACT_RESERVE) ? take : (inb_reg && cell_free);
        end
        else if (cmd.sweep_end)
        begin
            result_reg <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_granted_reg <= result_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_granted = out_granted_reg;
    assign status      = '{cnt_last: (cnt_reg == LAST_IDX),
                           out_free: (!out_valid_reg || out_ready)};

endmodule
`default_nettype wire

[rtl/core/tile_reservation_lease_table.sv]
// Tile lease table: query and reserve pass the index, read and evaluate states to the result
// register. Release and expire sweep every cell of the lease store, which has one read port
// and one write port. One request is in work at a time.
// After reset a clearing pass frees every cell; no request is taken meanwhile,
// configuration writes are.
`default_nettype none
module tile_reservation_lease_table #(
    parameter int MAX_SIDE  = trlt_pkg::MAX_SIDE_DEF,
    parameter int SLOT_BITS = trlt_pkg::SLOT_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    trlt_req_if.sink   req,
    trlt_rsp_if.source rsp,
    trlt_cfg_if.sink   cfg
);
    import trlt_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;
    logic    req_ready;

    assign req.ready = req_ready;
    assign cfg.ready = 1'b1;

    // Sequencer
    trlt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (action_t'(req.action)),
        .status     (status),
        .req_ready  (req_ready),
        .cmd        (cmd),
        .state      (state)
    );

    // Store and arithmetic
    trlt_datapath #(
        .MAX_SIDE  (MAX_SIDE),
        .SLOT_BITS (SLOT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_action     (req.action),
        .in_tile_x     (req.tile_x),
        .in_tile_y     (req.tile_y),
        .in_slot       (req.slot),
        .in_now_tick   (req.now_tick),
        .in_hold_ticks (req.hold_ticks),
        .cfg_write     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_valid     (rsp.valid),
        .out_granted   (rsp.granted),
        .out_ready     (rsp.ready)
    );

`ifndef SYNTH
    // A taken request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous one in work");

    // The clearing pass takes no request and shows no result
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> (!req.ready && !rsp.valid))
        else $error("activity during clearing pass");

    // A result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp.valid || rsp.ready))
        else $error("pending result overwritten");

    // Results leave the sequencer only from the done state
    a_load_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state == ST_DONE))
        else $error("result loaded outside done state");
`endif

endmodule
`default_nettype wire

[bench/tile_reservation_lease_table_tb.sv]
// Self-checking testbench for the tile lease table: directed table, then random requests.
`timescale 1ns / 1ps
module tile_reservation_lease_table_tb;
    import trlt_pkg::*;

    localparam int SIDE  = MAX_SIDE_DEF;
    localparam int CELLS = SIDE * SIDE;
    localparam logic [SLOT_W-1:0] NO_OWNER = '1;
    localparam int RANDOM_PER_PHASE = 29;

    typedef struct {
        action_t                   action;
        logic signed [COORD_W-1:0] tile_x;
        logic signed [COORD_W-1:0] tile_y;
        logic [SLOT_W-1:0]         slot;
        logic [TICK_W-1:0]         now_tick;
        logic [HOLD_W-1:0]         hold_ticks;
    } lease_req_t;

    typedef enum {ROW_CFG, ROW_REQ} row_kind_t;
    typedef enum {OUT_MODEL, OUT_DENY, OUT_GRANT} outcome_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        lease_req_t             rq;
        outcome_t               outcome;
    } stim_row_t;

    typedef struct {
        bit          granted;
        int unsigned seq;
        action_t     action;
    } grant_expect_t;

    logic clk;
    logic rst_n;

    trlt_req_if req_ch ();
    trlt_rsp_if rsp_ch ();
    trlt_cfg_if cfg_ch ();

    tile_reservation_lease_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the lease store and grid size
    logic [SLOT_W-1:0]     shadow_owner  [CELLS];
    logic [EXPIRY_W-1:0]   shadow_expiry [CELLS];
    logic [CFG_DATA_W-1:0] shadow_width;
    logic [CFG_DATA_W-1:0] shadow_height;

    grant_expect_t pending_grants[$];
    stim_row_t     directed_rows[$];
    int unsigned   request_seq;
    int unsigned   mismatch_count;
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    logic [TICK_W-1:0] tick_base;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int side_in_use(input logic [CFG_DATA_W-1:0] v);
        return (v > SIDE) ? SIDE : int'(v);
    endfunction

    // Maps a tile onto the flat store; 0 when outside the active grid
    function automatic bit locate_tile(input lease_req_t rq, output int idx);
        int w;
        int h;
        int x;
        int y;
        w   = side_in_use(shadow_width);
        h   = side_in_use(shadow_height);
        x   = int'(rq.tile_x);
        y   = int'(rq.tile_y);
        idx = 0;
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b0;
        idx = y * w + x;
        return 1'b1;
    endfunction

    function automatic bit cell_free(input int i, input logic [TICK_W-1:0] now);
        return shadow_owner[i] == NO_OWNER || shadow_expiry[i] <= {1'b0, now};
    endfunction

    // Predicts the grant and updates the shadow store
    function automatic bit apply_lease_request(input lease_req_t rq);
        int idx;
        bit hit;
        bit granted;
        granted = 1'b0;
        hit     = locate_tile(rq, idx);
        case (rq.action)
            ACT_QUERY:
            begin
                granted = hit && cell_free(idx, rq.now_tick);
            end
            ACT_RESERVE:
            begin
                if (hit && (cell_free(idx, rq.now_tick) || rq.slot < shadow_owner[idx]))
                begin
                    shadow_owner[idx]  = rq.slot;
                    shadow_expiry[idx] = {1'b0, rq.now_tick} + EXPIRY_W'(rq.hold_ticks) + 1'b1;
                    granted = 1'b1;
                end
            end
            ACT_RELEASE:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    if (shadow_owner[i] == rq.slot)
                    begin
                        shadow_owner[i]  = NO_OWNER;
                        shadow_expiry[i] = '0;
                    end
                end
                granted = 1'b1;
            end
            default:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    if (shadow_owner[i] != NO_OWNER && shadow_expiry[i] <= {1'b0, rq.now_tick})
                    begin
                        shadow_owner[i]  = NO_OWNER;
                        shadow_expiry[i] = '0;
                    end
                end
                granted = 1'b1;
            end
        endcase
        return granted;
    endfunction

    function automatic void add_request(input action_t a, input int x, input int y,
                                        input int slot, input logic [TICK_W-1:0] now,
                                        input int hold, input outcome_t outcome);
        stim_row_t row;
        row.kind          = ROW_REQ;
        row.reg_index     = REG_GRID_WIDTH;
        row.reg_data      = '0;
        row.rq.action     = a;
        row.rq.tile_x     = COORD_W'(x);
        row.rq.tile_y     = COORD_W'(y);
        row.rq.slot       = SLOT_W'(slot);
        row.rq.now_tick   = now;
        row.rq.hold_ticks = HOLD_W'(hold);
        row.outcome       = outcome;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind      = ROW_CFG;
        row.reg_index = idx;
        row.reg_data  = data;
        row.outcome   = OUT_MODEL;
        directed_rows.push_back(row);
    endfunction

    // Random request, mostly inside the grid with a small pool of slots
    function automatic lease_req_t random_lease_request();
        lease_req_t  rq;
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        w    = side_in_use(shadow_width);
        h    = side_in_use(shadow_height);
        pick = $urandom_range(0, 99);
        rq.action = (pick < 38) ? ACT_QUERY :
                    (pick < 78) ? ACT_RESERVE :
                    (pick < 89) ? ACT_RELEASE : ACT_EXPIRE;
        if ($urandom_range(0, 99) < 85)
        begin
            rq.tile_x = COORD_W'($urandom_range(0, w));
            rq.tile_y = COORD_W'($urandom_range(0, h));
        end
        else
        begin
            rq.tile_x = COORD_W'($urandom);
            rq.tile_y = COORD_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 75)
            rq.slot = SLOT_W'($urandom_range(0, 5));
        else if (pick < 85)
            rq.slot = NO_OWNER;
        else if (pick < 90)
            rq.slot = NO_OWNER - 1'b1;
        else
            rq.slot = SLOT_W'($urandom);
        tick_base = tick_base + TICK_W'($urandom_range(0, 12));
        pick = $urandom_range(0, 99);
        if (pick < 90)
            rq.now_tick = tick_base;
        else if (pick < 95)
            rq.now_tick = TICK_W'($urandom);
        else
            rq.now_tick = '1 - TICK_W'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 80)
            rq.hold_ticks = HOLD_W'($urandom_range(0, 30));
        else
            rq.hold_ticks = HOLD_W'($urandom);
        return rq;
    endfunction

    // Drive one request and record what it should return
    task automatic send_request(input lease_req_t rq, input outcome_t outcome);
        grant_expect_t ex;
        bit            model_grant;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= rq.action;
        req_ch.tile_x     <= rq.tile_x;
        req_ch.tile_y     <= rq.tile_y;
        req_ch.slot       <= rq.slot;
        req_ch.now_tick   <= rq.now_tick;
        req_ch.hold_ticks <= rq.hold_ticks;
        do
            @(posedge clk);
        while (!req_ch.ready);
        model_grant = apply_lease_request(rq);
        ex.granted  = (outcome == OUT_MODEL) ? model_grant : (outcome == OUT_GRANT);
        ex.seq      = request_seq;
        ex.action   = rq.action;
        pending_grants.push_back(ex);
        request_seq++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_GRID_WIDTH)
            shadow_width = data;
        else if (idx == REG_GRID_HEIGHT)
            shadow_height = data;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle_requests();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result receiver back-pressure
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result with the oldest outstanding request
    always @(posedge clk)
    begin : check_results
        grant_expect_t ex;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_grants.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                ex = pending_grants.pop_front();
                if (rsp_ch.granted !== ex.granted)
                    report_mismatch($sformatf("request %0d (%s): granted %b, expected %b",
                                              ex.seq, ex.action.name(), rsp_ch.granted,
                                              ex.granted));
            end
        end
    end

    // Reset, directed table, then random phases
    initial
    begin
        int unsigned send_mode [4];
        int unsigned recv_mode [4];
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_QUERY;
        req_ch.tile_x     = '0;
        req_ch.tile_y     = '0;
        req_ch.slot       = '0;
        req_ch.now_tick   = '0;
        req_ch.hold_ticks = '0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_GRID_WIDTH;
        cfg_ch.data       = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        request_seq       = 0;
        mismatch_count    = 0;
        tick_base         = TICK_W'($urandom_range(0, 1000));
        shadow_width      = GRID_SIDE_RESET;
        shadow_height     = GRID_SIDE_RESET;
        for (int i = 0; i < CELLS; i++)
        begin
            shadow_owner[i]  = NO_OWNER;
            shadow_expiry[i] = '0;
        end
        send_mode = '{0, 82, 0, 23};
        recv_mode = '{0, 0, 82, 23};

        // Free after reset, grid corners, out of bounds tiles
        add_request(ACT_QUERY,   0,      0,     0,      32'd0,        0,     OUT_GRANT);
        add_request(ACT_QUERY,   63,     63,    0,      32'd0,        0,     OUT_GRANT);
        add_request(ACT_QUERY,   64,     0,     0,      32'd0,        0,     OUT_DENY);
        add_request(ACT_QUERY,   -32768, 0,     0,      32'd0,        0,     OUT_DENY);
        add_request(ACT_QUERY,   0,      32767, 0,      32'd0,        0,     OUT_DENY);
        // Take a tile, same and higher slot refused, lower slot displaces
        add_request(ACT_RESERVE, 5,      5,     7,      32'd100,      10,    OUT_MODEL);
        add_request(ACT_RESERVE, 5,      5,     7,      32'd105,      3,     OUT_MODEL);
        add_request(ACT_RESERVE, 5,      5,     9,      32'd105,      3,     OUT_MODEL);
        add_request(ACT_RESERVE, 5,      5,     3,      32'd106,      0,     OUT_MODEL);
        // Expiry exactly at now counts as free
        add_request(ACT_QUERY,   5,      5,     0,      32'd106,      0,     OUT_MODEL);
        add_request(ACT_QUERY,   5,      5,     0,      32'd107,      0,     OUT_MODEL);
        // Reserving with the no-owner slot leaves the tile free
        add_request(ACT_RESERVE, 5,      5,     65535,  32'd200,      5,     OUT_MODEL);
        add_request(ACT_QUERY,   5,      5,     0,      32'd0,        0,     OUT_MODEL);
        // Expiry carrying into the top bit
        add_request(ACT_RESERVE, 10,     2,     0,      32'hFFFF_FFFF, 65535, OUT_MODEL);
        add_request(ACT_QUERY,   10,     2,     0,      32'hFFFF_FFFF, 0,     OUT_MODEL);
        add_request(ACT_EXPIRE,  0,      0,     0,      32'hFFFF_FFFF, 0,     OUT_GRANT);
        add_request(ACT_QUERY,   10,     2,     0,      32'hFFFF_FFFF, 0,     OUT_MODEL);
        add_request(ACT_RELEASE, 0,      0,     0,      32'd0,        0,     OUT_GRANT);
        add_request(ACT_QUERY,   10,     2,     0,      32'd0,        0,     OUT_MODEL);
        add_request(ACT_RELEASE, 0,      0,     65535,  32'd0,        0,     OUT_GRANT);
        // Oversized width with an empty grid
        add_config(REG_GRID_WIDTH,  7'd127);
        add_config(REG_GRID_HEIGHT, 7'd0);
        add_request(ACT_QUERY,   0,      0,     0,      32'd0,        0,     OUT_DENY);
        add_request(ACT_RESERVE, 0,      0,     1,      32'd0,        0,     OUT_DENY);
        // Resize keeps the store; the cell reappears at another tile
        add_config(REG_GRID_WIDTH,  7'd3);
        add_config(REG_GRID_HEIGHT, 7'd2);
        add_request(ACT_RESERVE, 2,      1,     4,      32'd50,       100,   OUT_MODEL);
        add_config(REG_GRID_WIDTH,  7'd64);
        add_config(REG_GRID_HEIGHT, 7'd64);
        add_request(ACT_QUERY,   5,      0,     0,      32'd60,       0,     OUT_MODEL);
        add_request(ACT_EXPIRE,  0,      0,     0,      32'd1000,     0,     OUT_GRANT);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                settle_requests();
                write_register(directed_rows[r].reg_index, directed_rows[r].reg_data);
            end
            else
            begin
                send_request(directed_rows[r].rq, directed_rows[r].outcome);
            end
        end

        // Random phases, each with its own grid size and idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            settle_requests();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            case (phase)
                0:
                begin
                    write_register(REG_GRID_WIDTH,  7'd4);
                    write_register(REG_GRID_HEIGHT, 7'd3);
                end
                1:
                begin
                    write_register(REG_GRID_WIDTH,  7'd64);
                    write_register(REG_GRID_HEIGHT, 7'd64);
                end
                2:
                begin
                    write_register(REG_GRID_WIDTH,  7'd127);
                    write_register(REG_GRID_HEIGHT, 7'd2);
                end
                default:
                begin
                    write_register(REG_GRID_WIDTH,  CFG_DATA_W'($urandom_range(1, 10)));
                    write_register(REG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(1, 10)));
                end
            endcase
            send_idle_pct  = send_mode[phase];
            recv_stall_pct = recv_mode[phase];
            repeat (RANDOM_PER_PHASE)
                send_request(random_lease_request(), OUT_MODEL);
        end

        settle_requests();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
